/* sv/hll_pkg.sv */
// ----------------------------------------------------------------------------
// hll_pkg
// Shared constants, types and helpers of the HyperLogLog cardinality sketch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hll_pkg;

  // sketch geometry
  localparam int unsigned IndexBits = 10;
  localparam int unsigned Buckets   = 1 << IndexBits;
  localparam int unsigned RestW     = 32 - IndexBits;
  localparam int unsigned RankW     = 5;
  localparam int unsigned FracBits  = 23;
  localparam int unsigned SumW      = IndexBits + 24;
  localparam int unsigned EstW      = 34;
  localparam int unsigned IdxOutW   = 10;

  // hash multipliers
  localparam logic [31:0] MixMulA = 32'h85eb_ca6b;
  localparam logic [31:0] MixMulB = 32'h c2b2_ae35;

  // alpha_m in 2.30 fixed point, rounded half up
  localparam longint unsigned AlphaNum =
      (Buckets == 16) ? (64'd673 << 30) :
      (Buckets == 32) ? (64'd697 << 30) :
      (Buckets == 64) ? (64'd709 << 30) :
      ((64'd7213 * Buckets) << 30);
  localparam longint unsigned AlphaDen =
      (Buckets == 16 || Buckets == 32 || Buckets == 64) ? 64'd1000 :
      (64'd10000 * Buckets + 64'd10790);
  localparam longint unsigned AlphaFix = (AlphaNum + AlphaDen / 2) / AlphaDen;

  // dividend of the estimate, with alpha's 2^30 scale brought down to the 2^23 scale of the sum
  localparam int unsigned   DivW   = 64;
  localparam int unsigned   DivCntW = $clog2(DivW);
  localparam logic [63:0]   EstNum = (AlphaFix * Buckets * Buckets) >> (30 - FracBits);

  // reset value of the harmonic sum: m terms of one
  localparam logic [SumW-1:0] SumReset = SumW'(Buckets) << FracBits;

  // queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  typedef struct packed {
    logic [IndexBits-1:0] idx;
    logic [RankW-1:0]     rank;
  } hll_entry_t;

  typedef enum logic [2:0] {
    BackClear,
    BackIdle,
    BackUpdate,
    BackDivide,
    BackDone
  } back_state_e;

  // harmonic term floor(2^(23-r)) in sum format
  function automatic logic [SumW-1:0] term_of(input logic [RankW-1:0] r);
    logic [SumW-1:0] t;
    t = '0;
    if (r <= RankW'(FracBits)) begin
      t = SumW'(1) << (RankW'(FracBits) - r);
    end
    return t;
  endfunction

endpackage

`default_nettype wire

/* sv/hll_front.sv */
// ----------------------------------------------------------------------------
// hll_front
// Three-stage hash pipeline: Murmur3 finalizer, bucket index and rank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hll_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [31:0]       item_value_i,
  output logic                   push_valid_o,
  input  wire logic              push_full_i,
  output hll_pkg::hll_entry_t    push_entry_o
);

  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;
  logic [31:0] p1_q, p2_q;
  logic [31:0] mix0, mix1, hash;
  logic [hll_pkg::RestW-1:0] rest;
  logic [hll_pkg::RankW-1:0] rank;
  hll_pkg::hll_entry_t ent_q, ent_d;

  // stage advance, a bubble collapses
  assign adv3 = !v3_q || !push_full_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_stall_o = !adv1;

  // hash arithmetic: one multiply ahead of p1_q and one ahead of p2_q
  assign mix0 = item_value_i ^ (item_value_i >> 16);
  assign mix1 = p1_q ^ (p1_q >> 13);
  assign hash = p2_q ^ (p2_q >> 16);
  assign rest = hash[hll_pkg::RestW-1:0];

  // rank: leading zeros of the remaining bits plus one
  always_comb begin
    rank = hll_pkg::RankW'(hll_pkg::RestW + 1);
    for (int i = 0; i < hll_pkg::RestW; i++) begin
      if (rest[i]) rank = hll_pkg::RankW'(hll_pkg::RestW - i);
    end
    ent_d.idx  = hash[31 -: hll_pkg::IndexBits];
    ent_d.rank = rank;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) p1_q <= 32'(mix0 * hll_pkg::MixMulA);
    if (adv2 && v1_q) p2_q <= 32'(mix1 * hll_pkg::MixMulB);
    if (adv3 && v2_q) ent_q <= ent_d;
  end

  assign push_valid_o = v3_q;
  assign push_entry_o = ent_q;

endmodule

`default_nettype wire

/* sv/hll_queue.sv */
// ----------------------------------------------------------------------------
// hll_queue
// Small queue of hashed items between the hash front and the update back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hll_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_valid_i,
  output logic                      full_o,
  input  wire hll_pkg::hll_entry_t  push_entry_i,
  output logic                      pop_valid_o,
  input  wire logic                 pop_i,
  output hll_pkg::hll_entry_t       pop_entry_o
);

  hll_pkg::hll_entry_t slots_q [hll_pkg::QDepth];
  logic [hll_pkg::QPtrW:0] wr_q, rd_q;
  logic push, pop;

  assign full_o = (wr_q[hll_pkg::QPtrW] != rd_q[hll_pkg::QPtrW]) &&
                  (wr_q[hll_pkg::QPtrW-1:0] == rd_q[hll_pkg::QPtrW-1:0]);
  assign pop_valid_o = (wr_q != rd_q);
  assign push = push_valid_i && !full_o;
  assign pop  = pop_i && pop_valid_o;
  assign pop_entry_o = slots_q[rd_q[hll_pkg::QPtrW-1:0]];

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) slots_q[wr_q[hll_pkg::QPtrW-1:0]] <= push_entry_i;
  end

endmodule

`default_nettype wire

/* sv/hll_back.sv */
// ----------------------------------------------------------------------------
// hll_back
// Rank store read-modify-write, harmonic sum update, estimate divider and
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hll_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       pop_valid_i,
  output logic                            pop_o,
  input  wire hll_pkg::hll_entry_t        pop_entry_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [hll_pkg::IdxOutW-1:0]     bucket_index_o,
  output logic [hll_pkg::RankW-1:0]       bucket_rank_o,
  output logic [hll_pkg::EstW-1:0]        cardinality_estimate_o
);

  hll_pkg::back_state_e state_q, state_d;

  logic [hll_pkg::RankW-1:0] mem [hll_pkg::Buckets];
  logic [hll_pkg::RankW-1:0] rdata_q;
  logic                      mem_we;
  logic [hll_pkg::IndexBits-1:0] mem_waddr;
  logic [hll_pkg::RankW-1:0] mem_wdata;

  logic [hll_pkg::IndexBits-1:0] clr_q;
  hll_pkg::hll_entry_t cur_q;
  logic [hll_pkg::RankW-1:0] new_rank_q;
  logic [hll_pkg::SumW-1:0]  sum_q;
  logic [hll_pkg::SumW-1:0]  rem_q;
  logic [hll_pkg::DivW-1:0]  quo_q;
  logic [hll_pkg::DivCntW-1:0] cnt_q;
  logic [hll_pkg::SumW:0]    trial;
  logic                      take;
  logic                      raise;
  logic                      clr_last;
  logic                      load_out;
  logic                      out_free;
  logic                      out_valid_q;
  logic [hll_pkg::IndexBits-1:0] out_idx_q;
  logic [hll_pkg::RankW-1:0] out_rank_q;
  logic [hll_pkg::EstW-1:0]  out_est_q;
  logic [hll_pkg::EstW-1:0]  est;

  assign clr_last = (clr_q == {hll_pkg::IndexBits{1'b1}});
  assign raise    = (cur_q.rank > rdata_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign trial    = {rem_q, quo_q[hll_pkg::DivW-1]};
  assign est      = (|quo_q[hll_pkg::DivW-1:hll_pkg::EstW]) ? {hll_pkg::EstW{1'b1}}
                                                           : quo_q[hll_pkg::EstW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hll_pkg::BackClear:  if (clr_last) state_d = hll_pkg::BackIdle;
      hll_pkg::BackIdle:   if (pop_valid_i) state_d = hll_pkg::BackUpdate;
      hll_pkg::BackUpdate: state_d = hll_pkg::BackDivide;
      hll_pkg::BackDivide: if (cnt_q == '0) state_d = hll_pkg::BackDone;
      hll_pkg::BackDone:   if (out_free) state_d = hll_pkg::BackIdle;
      default:             state_d = hll_pkg::BackClear;
    endcase
  end

  // control outputs
  always_comb begin
    take      = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cur_q.idx;
    mem_wdata = cur_q.rank;
    load_out  = 1'b0;
    case (state_q)
      hll_pkg::BackClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      hll_pkg::BackIdle:   take = pop_valid_i;
      hll_pkg::BackUpdate: mem_we = raise;
      hll_pkg::BackDone:   load_out = out_free;
      default: ;
    endcase
  end

  assign pop_o = take;

  // rank store
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[pop_entry_i.idx];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hll_pkg::BackClear;
      clr_q       <= '0;
      sum_q       <= hll_pkg::SumReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == hll_pkg::BackClear) clr_q <= clr_q + 1'b1;
      if (state_q == hll_pkg::BackUpdate && raise) begin
        sum_q <= sum_q - hll_pkg::term_of(rdata_q) + hll_pkg::term_of(cur_q.rank);
      end
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // item, divider and result payload
  always_ff @(posedge clk_i) begin
    if (take) cur_q <= pop_entry_i;
    if (state_q == hll_pkg::BackUpdate) begin
      new_rank_q <= raise ? cur_q.rank : rdata_q;
      rem_q      <= '0;
      quo_q      <= hll_pkg::EstNum;
      cnt_q      <= hll_pkg::DivCntW'(hll_pkg::DivW - 1);
    end
    // restoring division, one quotient bit per cycle
    if (state_q == hll_pkg::BackDivide) begin
      if (trial >= {1'b0, sum_q}) begin
        rem_q <= hll_pkg::SumW'(trial - {1'b0, sum_q});
        quo_q <= {quo_q[hll_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_q <= trial[hll_pkg::SumW-1:0];
        quo_q <= {quo_q[hll_pkg::DivW-2:0], 1'b0};
      end
      cnt_q <= cnt_q - 1'b1;
    end
    if (load_out) begin
      out_idx_q  <= cur_q.idx;
      out_rank_q <= new_rank_q;
      out_est_q  <= est;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign bucket_index_o         = hll_pkg::IdxOutW'(out_idx_q);
  assign bucket_rank_o          = out_rank_q;
  assign cardinality_estimate_o = out_est_q;

endmodule

`default_nettype wire

/* sv/hyperloglog_cardinality_sketch_top.sv */
// ----------------------------------------------------------------------------
// hyperloglog_cardinality_sketch_top
// HyperLogLog sketch: hashes each item, keeps per-bucket maximum ranks and
// returns bucket, rank and the raw cardinality estimate for every item.
// ----------------------------------------------------------------------------
// After reset the block clears its 1024-entry rank store, one entry a cycle,
// so no item is updated until the clear is done; meanwhile up to seven items
// are taken into the three-stage hash pipeline and the four-entry queue before
// the input stalls. The update side handles one item at a time: a rank store
// read, the update, the 64-bit bit-serial estimate divider and the load of the
// output register, which waits while the output is stalled. The divider sets
// the rate of the update side.
`timescale 1ns / 1ps
`default_nettype none

module hyperloglog_cardinality_sketch_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] item_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [9:0]       bucket_index_o,
  output logic [4:0]       bucket_rank_o,
  output logic [33:0]      cardinality_estimate_o
);

  logic push_valid, q_full, pop_valid, pop;
  hll_pkg::hll_entry_t push_entry, pop_entry;

  // hash front
  hll_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .item_value_i (item_value_i),
    .push_valid_o (push_valid),
    .push_full_i  (q_full),
    .push_entry_o (push_entry)
  );

  // decoupling queue
  hll_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .full_o       (q_full),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry)
  );

  // update back
  hll_back u_back (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .pop_valid_i            (pop_valid),
    .pop_o                  (pop),
    .pop_entry_i            (pop_entry),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .bucket_index_o         (bucket_index_o),
    .bucket_rank_o          (bucket_rank_o),
    .cardinality_estimate_o (cardinality_estimate_o)
  );

endmodule

`default_nettype wire

/* sv/hll_checker.sv */
// ----------------------------------------------------------------------------
// hll_checker
// Port-level checks of the sketch, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hll_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [9:0]  bucket_index_o,
  input wire logic [4:0]  bucket_rank_o,
  input wire logic [33:0] cardinality_estimate_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bucket_index_o) &&
    $stable(bucket_rank_o) && $stable(cardinality_estimate_o))
    else $error("stalled item changed");

  // no result straight out of reset
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("item during reset");

  // stored rank is at least one and within range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bucket_rank_o != 5'd0 &&
    bucket_rank_o <= 5'(hll_pkg::RestW + 1))
    else $error("rank out of range");

  // estimate never reaches zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cardinality_estimate_o != 34'd0)
    else $error("zero estimate");

endmodule

bind hyperloglog_cardinality_sketch_top hll_checker u_hll_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .out_valid_o            (out_valid_o),
  .out_stall_i            (out_stall_i),
  .bucket_index_o         (bucket_index_o),
  .bucket_rank_o          (bucket_rank_o),
  .cardinality_estimate_o (cardinality_estimate_o)
);

`default_nettype wire

/* tb/hyperloglog_cardinality_sketch_top_tb.sv */
// ----------------------------------------------------------------------------
// hyperloglog_cardinality_sketch_top_tb
// Drives inserts into the sketch and checks bucket, rank and estimate
// of every result against a predictor that keeps its own rank store and sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// expected results of the sketch, in order
class hll_scoreboard;
  logic [4:0]  ranks [1024];
  logic [33:0] hsum;
  logic [9:0]  exp_idx [$];
  logic [4:0]  exp_rank [$];
  logic [33:0] exp_est [$];
  int          errors;

  function new();
    foreach (ranks[i]) ranks[i] = '0;
    hsum   = 34'd1024 << 23;
    errors = 0;
  endfunction

  function logic [31:0] mix(logic [31:0] v);
    v = v ^ (v >> 16);
    v = v * 32'h85ebca6b;
    v = v ^ (v >> 13);
    v = v * 32'hc2b2ae35;
    v = v ^ (v >> 16);
    return v;
  endfunction

  function logic [33:0] term(logic [4:0] r);
    if (r > 5'd23) return '0;
    return 34'd1 << (23 - r);
  endfunction

  // note an accepted item and predict its result
  function void note_item(logic [31:0] value);
    logic [31:0]     h;
    logic [31:0]     rest;
    logic [9:0]      idx;
    logic [4:0]      r;
    longint unsigned alpha;
    longint unsigned num;
    longint unsigned est;
    h    = mix(value);
    idx  = h[31:22];
    rest = h << 10;
    r    = 5'd1;
    while (r < 5'd23 && !rest[31]) begin
      r++;
      rest = rest << 1;
    end
    if (r > ranks[idx]) begin
      hsum       = hsum - term(ranks[idx]) + term(r);
      ranks[idx] = r;
    end
    alpha = ((64'd7213 * 1024) << 30) + (64'd10000 * 1024 + 64'd10790) / 2;
    alpha = alpha / (64'd10000 * 1024 + 64'd10790);
    num   = alpha * 1024 * 1024;
    if (hsum == 0) est = 64'h3_ffff_ffff;
    else begin
      est = num / ({30'd0, hsum} << 7);
      if (est > 64'h3_ffff_ffff) est = 64'h3_ffff_ffff;
    end
    exp_idx.push_back(idx);
    exp_rank.push_back(ranks[idx]);
    exp_est.push_back(est[33:0]);
  endfunction

  function void report(string what);
    $display("mismatch: %s", what);
    errors++;
  endfunction

  // compare a result with the oldest expectation
  function void check_result(logic [9:0] idx, logic [4:0] r, logic [33:0] est);
    logic [9:0]  ei;
    logic [4:0]  er;
    logic [33:0] ee;
    if (exp_idx.size() == 0) begin
      report("result with no item pending");
      return;
    end
    ei = exp_idx.pop_front();
    er = exp_rank.pop_front();
    ee = exp_est.pop_front();
    if (idx !== ei) report($sformatf("bucket %0d, expected %0d", idx, ei));
    if (r !== er) report($sformatf("rank %0d, expected %0d", r, er));
    if (est !== ee) report($sformatf("estimate %0d, expected %0d", est, ee));
  endfunction
endclass

module hyperloglog_cardinality_sketch_top_tb;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] item_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [9:0]  bucket_index_o;
  logic [4:0]  bucket_rank_o;
  logic [33:0] cardinality_estimate_o;

  hll_scoreboard sb = new();
  bit  calm;
  bit  hold_rx;
  int  idle_cycles;

  hyperloglog_cardinality_sketch_top u_dut (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: check and stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(bucket_index_o, bucket_rank_o, cardinality_estimate_o);
    out_stall_i <= hold_rx || (!calm && $urandom_range(99) < 8);
  end

  // watchdog on accept-free cycles
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // offer one item and hold it until accepted
  task automatic send_item(logic [31:0] v);
    while (!calm && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    item_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(v);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.exp_idx.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] v;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: field extremes and single-bit values
    send_item(32'h0);
    send_item(32'hffff_ffff);
    send_item(32'h8000_0000);
    send_item(32'h7fff_ffff);
    send_item(32'h1);
    send_item(32'h0);
    for (int i = 0; i < 12; i++) send_item(32'h1 << (i * 3 % 32));
    drain();
    // receiver holds off long while sender keeps offering
    fork
      begin
        hold_rx = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      for (int i = 0; i < 10; i++) send_item($urandom);
    join
    drain();
    // random, first stretch with no idling
    calm = 1'b1;
    for (int i = 0; i < 100; i++) send_item($urandom);
    calm = 1'b0;
    for (int i = 0; i < 470; i++) begin
      v = $urandom;
      if ($urandom_range(9) == 0) v = v & 32'h0000_00ff;
      send_item(v);
    end
    drain();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.exp_idx.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

/* hyperloglog_cardinality_sketch_top.f */
sv/hll_pkg.sv
sv/hll_front.sv
sv/hll_queue.sv
sv/hll_back.sv
sv/hyperloglog_cardinality_sketch_top.sv
sv/hll_checker.sv
tb/hyperloglog_cardinality_sketch_top_tb.sv
